// File: src/inode_refcount_cache_defines.svh
// ---------------------------------------------------------------------------
// inode_refcount_cache_defines: assertion macros
// shared by the modules of the inode table that carry assertions
// ---------------------------------------------------------------------------
`ifndef INODE_REFCOUNT_CACHE_DEFINES_SVH
`define INODE_REFCOUNT_CACHE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define IRC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define IRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/irc_pkg.sv
// ---------------------------------------------------------------------------
// irc_pkg
// types, codes and widths shared by the inode table modules
// ---------------------------------------------------------------------------
package irc_pkg;

    localparam int OP_W        = 2;
    localparam int DEV_W       = 16;
    localparam int NUM_W       = 12;
    localparam int SLOT_W      = 6;
    localparam int STATUS_W    = 3;
    localparam int SECTOR_W    = 32;
    localparam int OFFSET_W    = 9;
    localparam int COUNT_W     = 8;
    localparam int IMAP_W      = 8;
    localparam int SMAP_W      = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int SLOTS_DEF        = 64;
    localparam int SECTOR_BYTES_DEF = 512;
    localparam int INODE_BYTES_DEF  = 32;

    // boot sector and super block ahead of the maps
    localparam int BOOT_SECTORS = 1 + 1;

    localparam logic [IMAP_W-1:0]  IMAP_RESET = IMAP_W'(1);
    localparam logic [SMAP_W-1:0]  SMAP_RESET = SMAP_W'(1);
    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_GET    = 2'd0,
        OP_PUT    = 2'd1,
        OP_LOCATE = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT        = 3'd0,
        ST_CLAIMED    = 3'd1,
        ST_INODE_ZERO = 3'd2,
        ST_FULL       = 3'd3,
        ST_UNUSED     = 3'd4
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAP = 2'd0,
        CFG_SMAP = 2'd1
    } cfg_index_t;

    typedef enum logic [2:0] {
        CTL_CLEAR,
        CTL_IDLE,
        CTL_SCAN,
        CTL_CHECK,
        CTL_LOCATE,
        CTL_FINISH
    } ctl_state_t;

    typedef enum logic [1:0] {
        LOC_IDLE,
        LOC_DIV,
        LOC_SUM,
        LOC_DONE
    } loc_state_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [DEV_W-1:0]   device;
        logic [NUM_W-1:0]   inode;
    } entry_t;

    typedef struct packed {
        status_t             status;
        logic [SLOT_W-1:0]   slot;
        logic [SECTOR_W-1:0] sector;
        logic [OFFSET_W-1:0] offset;
        logic [COUNT_W-1:0]  count;
    } res_t;

endpackage

// File: src/irc_table.sv
// ---------------------------------------------------------------------------
// irc_table
// slot store: one write port, one read port, registered read data
// ---------------------------------------------------------------------------
module irc_table #(
    parameter int SLOTS = irc_pkg::SLOTS_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(SLOTS)-1:0] wr_addr,
    input  irc_pkg::entry_t          wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(SLOTS)-1:0] rd_addr,
    output irc_pkg::entry_t          rd_data
);
    import irc_pkg::*;

    entry_t entry_reg [SLOTS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= entry_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/irc_locate.sv
// ---------------------------------------------------------------------------
// irc_locate
// disk place of an inode record: division by records per sector through a
// constant reciprocal multiplication
// ---------------------------------------------------------------------------
`include "inode_refcount_cache_defines.svh"

module irc_locate #(
    parameter int SECTOR_BYTES = irc_pkg::SECTOR_BYTES_DEF,
    parameter int INODE_BYTES  = irc_pkg::INODE_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [irc_pkg::NUM_W-1:0]      idx,
    input  logic [irc_pkg::IMAP_W-1:0]     imap_sectors,
    input  logic [irc_pkg::SMAP_W-1:0]     smap_sectors,
    output logic                           done,
    output logic [irc_pkg::SECTOR_W-1:0]   sector,
    output logic [irc_pkg::OFFSET_W-1:0]   offset
);
    import irc_pkg::*;

    localparam int PER_RAW = SECTOR_BYTES / INODE_BYTES;
    localparam int PER     = (PER_RAW < 1) ? 1 : PER_RAW;
    localparam int SHIFT   = NUM_W + $clog2(PER);
    localparam int RECIP   = ((1 << SHIFT) + PER - 1) / PER;
    localparam int STRIDE  = PER * INODE_BYTES;

    loc_state_t          state_reg, state_next;
    logic [NUM_W-1:0]    idx_reg, idx_next;
    logic [NUM_W-1:0]    quo_reg, quo_next;
    logic [SECTOR_W-1:0] sector_reg, sector_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LOC_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        quo_reg    <= quo_next;
        sector_reg <= sector_next;
        offset_reg <= offset_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        quo_next    = quo_reg;
        sector_next = sector_reg;
        offset_next = offset_reg;
        case (state_reg)
            LOC_IDLE:
            begin
                if (start)
                begin
                    idx_next   = idx;
                    state_next = LOC_DIV;
                end
            end
            LOC_DIV:
            begin
                // quotient exact for every 12-bit index
                quo_next   = NUM_W'((32'(idx_reg) * 32'(RECIP)) >> SHIFT);
                state_next = LOC_SUM;
            end
            LOC_SUM:
            begin
                sector_next = SECTOR_W'(BOOT_SECTORS) + SECTOR_W'(imap_sectors)
                            + SECTOR_W'(smap_sectors) + SECTOR_W'(quo_reg);
                offset_next = OFFSET_W'(32'(idx_reg) * 32'(INODE_BYTES)
                                        - 32'(quo_reg) * 32'(STRIDE));
                state_next  = LOC_DONE;
            end
            LOC_DONE:
            begin
                state_next = LOC_IDLE;
            end
            default:
            begin
                state_next = LOC_IDLE;
            end
        endcase
    end

    assign done   = (state_reg == LOC_DONE);
    assign sector = sector_reg;
    assign offset = offset_reg;

    `IRC_ASSERT_NOW(a_start_when_idle, start, state_reg == LOC_IDLE, "locate started while busy")
    `IRC_ASSERT_NEXT(a_div_to_sum, state_reg == LOC_DIV,
        state_reg == LOC_SUM, "division did not end after one cycle")

endmodule

// File: src/irc_ctrl.sv
// ---------------------------------------------------------------------------
// irc_ctrl
// sequencer: clearing sweep, slot scan, read-modify-write of one slot
// ---------------------------------------------------------------------------
`include "inode_refcount_cache_defines.svh"

module irc_ctrl #(
    parameter int SLOTS = irc_pkg::SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  logic [irc_pkg::OP_W-1:0]       op,
    input  logic [irc_pkg::DEV_W-1:0]      device,
    input  logic [irc_pkg::NUM_W-1:0]      inode_number,
    input  logic [irc_pkg::SLOT_W-1:0]     slot_in,
    output logic                           rd_en,
    output logic [$clog2(SLOTS)-1:0]       rd_addr,
    input  irc_pkg::entry_t                rd_data,
    output logic                           wr_en,
    output logic [$clog2(SLOTS)-1:0]       wr_addr,
    output irc_pkg::entry_t                wr_data,
    output logic                           loc_start,
    output logic [irc_pkg::NUM_W-1:0]      loc_idx,
    input  logic                           loc_done,
    input  logic [irc_pkg::SECTOR_W-1:0]   loc_sector,
    input  logic [irc_pkg::OFFSET_W-1:0]   loc_offset,
    output logic                           res_valid,
    input  logic                           res_take,
    output irc_pkg::res_t                  res
);
    import irc_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

    ctl_state_t         state_reg, state_next;
    logic [SW-1:0]      clr_reg, clr_next;
    logic [SW-1:0]      idx_reg, idx_next;
    logic [SW-1:0]      free_reg, free_next;
    logic               have_free_reg, have_free_next;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [DEV_W-1:0]   dev_reg, dev_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    res_t               res_reg, res_next;

    logic               occupied;
    logic               match;
    logic               any_free;
    logic [SW-1:0]      free_sel;
    logic [COUNT_W-1:0] count_inc;
    logic [COUNT_W-1:0] count_dec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CTL_CLEAR;
            clr_reg       <= '0;
            idx_reg       <= '0;
            have_free_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            idx_reg       <= idx_next;
            have_free_reg <= have_free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        free_reg <= free_next;
        op_reg   <= op_next;
        dev_reg  <= dev_next;
        num_reg  <= num_next;
        slot_reg <= slot_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        occupied  = (rd_data.count != '0);
        match     = occupied && (rd_data.device == dev_reg) && (rd_data.inode == num_reg);
        any_free  = have_free_reg || !occupied;
        free_sel  = have_free_reg ? free_reg : idx_reg;
        count_inc = (rd_data.count == COUNT_MAX) ? rd_data.count
                                                 : rd_data.count + 1'b1;
        count_dec = rd_data.count - 1'b1;

        state_next     = state_reg;
        clr_next       = clr_reg;
        idx_next       = idx_reg;
        free_next      = free_reg;
        have_free_next = have_free_reg;
        op_next        = op_reg;
        dev_next       = dev_reg;
        num_next       = num_reg;
        slot_next      = slot_reg;
        res_next       = res_reg;

        req_ready = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = '0;
        wr_en     = 1'b0;
        wr_addr   = '0;
        wr_data   = '0;
        loc_start = 1'b0;
        loc_idx   = '0;
        res_valid = 1'b0;

        case (state_reg)
            CTL_CLEAR:
            begin
                // every slot free after reset
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST)
                begin
                    state_next = CTL_IDLE;
                end
            end
            CTL_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    op_next   = op;
                    dev_next  = device;
                    num_next  = inode_number;
                    slot_next = slot_in;
                    res_next  = '0;
                    case (op)
                        OP_GET:
                        begin
                            if (inode_number == '0)
                            begin
                                res_next.status = ST_INODE_ZERO;
                                state_next      = CTL_FINISH;
                            end
                            else
                            begin
                                rd_en          = 1'b1;
                                rd_addr        = '0;
                                idx_next       = '0;
                                have_free_next = 1'b0;
                                state_next     = CTL_SCAN;
                            end
                        end
                        OP_PUT, OP_LOCATE:
                        begin
                            res_next.slot = slot_in;
                            if (32'(slot_in) >= 32'(SLOTS))
                            begin
                                res_next.status = ST_UNUSED;
                                state_next      = CTL_FINISH;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = SW'(slot_in);
                                state_next = CTL_CHECK;
                            end
                        end
                        default:
                        begin
                            res_next.status = ST_UNUSED;
                            state_next      = CTL_FINISH;
                        end
                    endcase
                end
            end
            CTL_SCAN:
            begin
                // rd_data holds slot idx_reg
                if (match)
                begin
                    wr_en           = 1'b1;
                    wr_addr         = idx_reg;
                    wr_data         = rd_data;
                    wr_data.count   = count_inc;
                    res_next.status = ST_HIT;
                    res_next.slot   = SLOT_W'(idx_reg);
                    res_next.count  = count_inc;
                    loc_start       = 1'b1;
                    loc_idx         = num_reg - 1'b1;
                    state_next      = CTL_LOCATE;
                end
                else if (idx_reg == LAST)
                begin
                    if (any_free)
                    begin
                        wr_en           = 1'b1;
                        wr_addr         = free_sel;
                        wr_data.count   = COUNT_W'(1);
                        wr_data.device  = dev_reg;
                        wr_data.inode   = num_reg;
                        res_next.status = ST_CLAIMED;
                        res_next.slot   = SLOT_W'(free_sel);
                        res_next.count  = COUNT_W'(1);
                        loc_start       = 1'b1;
                        loc_idx         = num_reg - 1'b1;
                        state_next      = CTL_LOCATE;
                    end
                    else
                    begin
                        res_next.status = ST_FULL;
                        state_next      = CTL_FINISH;
                    end
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + 1'b1;
                    idx_next = idx_reg + 1'b1;
                    if (!occupied && !have_free_reg)
                    begin
                        have_free_next = 1'b1;
                        free_next      = idx_reg;
                    end
                end
            end
            CTL_CHECK:
            begin
                if (!occupied)
                begin
                    res_next.status = ST_UNUSED;
                    state_next      = CTL_FINISH;
                end
                else
                begin
                    res_next.status = ST_HIT;
                    res_next.count  = rd_data.count;
                    if (op_reg == OP_PUT)
                    begin
                        wr_en          = 1'b1;
                        wr_addr        = SW'(slot_reg);
                        wr_data        = rd_data;
                        wr_data.count  = count_dec;
                        res_next.count = count_dec;
                    end
                    loc_start  = 1'b1;
                    loc_idx    = rd_data.inode - 1'b1;
                    state_next = CTL_LOCATE;
                end
            end
            CTL_LOCATE:
            begin
                if (loc_done)
                begin
                    res_next.sector = loc_sector;
                    res_next.offset = loc_offset;
                    state_next      = CTL_FINISH;
                end
            end
            CTL_FINISH:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = CTL_IDLE;
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    `IRC_ASSERT_NOW(a_no_same_slot_rw, wr_en && rd_en, wr_addr != rd_addr,
        "read and write of one slot in the same cycle")
    `IRC_ASSERT_NEXT(a_loc_to_finish, (state_reg == CTL_LOCATE) && loc_done,
        res_valid, "located result not presented")
    `IRC_ASSERT_NOW(a_scan_steps_by_one,
        (state_reg == CTL_SCAN) && ($past(state_reg) == CTL_SCAN),
        idx_reg == SW'($past(idx_reg) + 1'b1), "scan skipped a slot")
    `IRC_ASSERT_NEXT(a_claim_one, (state_reg == CTL_SCAN) && wr_en && !match,
        res_reg.count == COUNT_W'(1), "claimed slot without a count of one")

endmodule

// File: src/inode_refcount_cache.sv
// ---------------------------------------------------------------------------
// inode_refcount_cache
// reference-counted inode table with disk placement of inode records
// ---------------------------------------------------------------------------
// request channel: req_valid/req_ready with op, device, inode_number and
//   slot_in; one response beat per request beat, in order.
// response channel: rsp_valid/rsp_ready with status, slot_out, sector,
//   byte_offset and use_count, held in an output register.
// config port: cfg_write with cfg_index (0 imap_sectors, 1 smap_sectors) and
//   cfg_data, taken on any cycle; change it only while the table is quiet.
// one request at a time. a get walks the slot store one slot per cycle on
//   its single read port. put and locate read one slot. a refused get, a
//   slot beyond the table or an unknown op answers without reading the
//   store. placement by reciprocal multiplication adds the division, sum
//   and done states of irc_locate.
// after reset the store is swept free, one slot per cycle, across all SLOTS slots;
//   req_ready stays low until the sweep is done. config registers reset to 1.
// a stalled response holds in the output register; the next request is
//   taken and worked on meanwhile, and its result waits until the register
//   empties.
// ---------------------------------------------------------------------------
module inode_refcount_cache #(
    parameter int SLOTS        = irc_pkg::SLOTS_DEF,
    parameter int SECTOR_BYTES = irc_pkg::SECTOR_BYTES_DEF,
    parameter int INODE_BYTES  = irc_pkg::INODE_BYTES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [irc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [irc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  logic [irc_pkg::OP_W-1:0]          op,
    input  logic [irc_pkg::DEV_W-1:0]         device,
    input  logic [irc_pkg::NUM_W-1:0]         inode_number,
    input  logic [irc_pkg::SLOT_W-1:0]        slot_in,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output logic [irc_pkg::STATUS_W-1:0]      status,
    output logic [irc_pkg::SLOT_W-1:0]        slot_out,
    output logic [irc_pkg::SECTOR_W-1:0]      sector,
    output logic [irc_pkg::OFFSET_W-1:0]      byte_offset,
    output logic [irc_pkg::COUNT_W-1:0]       use_count
);
    import irc_pkg::*;

    localparam int SW = $clog2(SLOTS);

    logic [IMAP_W-1:0]   imap_reg, imap_next;
    logic [SMAP_W-1:0]   smap_reg, smap_next;
    logic                rsp_valid_reg, rsp_valid_next;
    res_t                rsp_reg, rsp_next;

    logic                rd_en;
    logic [SW-1:0]       rd_addr;
    entry_t              rd_data;
    logic                wr_en;
    logic [SW-1:0]       wr_addr;
    entry_t              wr_data;
    logic                loc_start;
    logic [NUM_W-1:0]    loc_idx;
    logic                loc_done;
    logic [SECTOR_W-1:0] loc_sector;
    logic [OFFSET_W-1:0] loc_offset;
    logic                res_valid;
    logic                res_take;
    res_t                res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            imap_reg      <= IMAP_RESET;
            smap_reg      <= SMAP_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            imap_reg      <= imap_next;
            smap_reg      <= smap_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    always_comb
    begin
        imap_next = imap_reg;
        smap_next = smap_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_IMAP: imap_next = cfg_data[IMAP_W-1:0];
                CFG_SMAP: smap_next = cfg_data[SMAP_W-1:0];
                default:  ;
            endcase
        end
    end

    // output register frees when empty or when its beat goes out
    assign res_take = res_valid && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (res_take)
        begin
            rsp_next       = res;
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    irc_table #(
        .SLOTS (SLOTS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    irc_locate #(
        .SECTOR_BYTES (SECTOR_BYTES),
        .INODE_BYTES  (INODE_BYTES)
    ) u_locate (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (loc_start),
        .idx          (loc_idx),
        .imap_sectors (imap_reg),
        .smap_sectors (smap_reg),
        .done         (loc_done),
        .sector       (loc_sector),
        .offset       (loc_offset)
    );

    irc_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .op           (op),
        .device       (device),
        .inode_number (inode_number),
        .slot_in      (slot_in),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .loc_start    (loc_start),
        .loc_idx      (loc_idx),
        .loc_done     (loc_done),
        .loc_sector   (loc_sector),
        .loc_offset   (loc_offset),
        .res_valid    (res_valid),
        .res_take     (res_take),
        .res          (res)
    );

    assign rsp_valid   = rsp_valid_reg;
    assign status      = rsp_reg.status;
    assign slot_out    = rsp_reg.slot;
    assign sector      = rsp_reg.sector;
    assign byte_offset = rsp_reg.offset;
    assign use_count   = rsp_reg.count;

endmodule

// File: bench/tb_inode_refcount_cache.sv
// ----------------------------------------------------------------------------
// tb_inode_refcount_cache
// Self-checking bench for the reference-counted inode table. It first walks a
// short table of directed requests: inode zero, free slots, unknown op, claims,
// hits and releases. Rows whose answer is obvious carry it typed in. A
// constrained-by-hand random part then runs under four map-size settings,
// including both extremes. It exercises a small working set of inodes, fills
// the table until it is full, drains it again, saturates one use count, and
// mixes in noise. Every response beat is checked field by field against the
// typed answer where its row has one, else against an in-bench model of the
// table. The request side sends in bursts, the response side stalls on its
// own pattern, and once it holds off long enough for the input to back up.
// ----------------------------------------------------------------------------
module tb_inode_refcount_cache;
    timeunit 1ns;
    timeprecision 1ps;

    import irc_pkg::*;

    localparam int NSLOTS          = SLOTS_DEF;
    localparam int RECS_PER_SECTOR = (SECTOR_BYTES_DEF / INODE_BYTES_DEF) < 1 ?
                                     1 : SECTOR_BYTES_DEF / INODE_BYTES_DEF;
    localparam logic [OP_W-1:0]        OP_UNKNOWN = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_NONE   = 2'd3;
    localparam int QUIET_LIMIT  = 4000;
    localparam int LONG_HOLD    = 300;
    localparam int TAIL_CYCLES  = 100;
    localparam int PHASE_ITEMS  = 160;
    localparam int SAT_HITS     = 258;
    localparam int POOL_SIZE    = 6;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [DEV_W-1:0]  dev;
        logic [NUM_W-1:0]  num;
        logic [SLOT_W-1:0] slot;
        bit                known;
        res_t              res;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   req_valid;
    logic                   req_ready;
    logic [OP_W-1:0]        op;
    logic [DEV_W-1:0]       device;
    logic [NUM_W-1:0]       inode_number;
    logic [SLOT_W-1:0]      slot_in;
    logic                   rsp_valid;
    logic                   rsp_ready;
    logic [STATUS_W-1:0]    status;
    logic [SLOT_W-1:0]      slot_out;
    logic [SECTOR_W-1:0]    sector;
    logic [OFFSET_W-1:0]    byte_offset;
    logic [COUNT_W-1:0]     use_count;

    // model of the table
    logic [COUNT_W-1:0] slot_count [NSLOTS];
    logic [DEV_W-1:0]   slot_device[NSLOTS];
    logic [NUM_W-1:0]   slot_inode [NSLOTS];
    logic [IMAP_W-1:0]  imap_cfg;
    logic [SMAP_W-1:0]  smap_cfg;

    res_t     results_due[$];
    res_t     want_res;
    dir_row_t dir_rows[$];

    logic [DEV_W-1:0] pool_dev[POOL_SIZE];
    logic [NUM_W-1:0] pool_num[POOL_SIZE];

    int    errors       = 0;
    int    items_sent   = 0;
    int    burst_left   = 0;
    int    quiet_cycles = 0;
    bit    hold_rsp     = 1'b0;
    int    pat_mode     = 0;
    int    pat_left     = 0;
    int    pat_pos      = 0;
    logic [15:0] stall_pat = '1;

    inode_refcount_cache dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .op           (op),
        .device       (device),
        .inode_number (inode_number),
        .slot_in      (slot_in),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .status       (status),
        .slot_out     (slot_out),
        .sector       (sector),
        .byte_offset  (byte_offset),
        .use_count    (use_count)
    );

    always #10 clk = ~clk;

    function automatic void place_record(input logic [NUM_W-1:0] n,
                                         output logic [SECTOR_W-1:0] sec,
                                         output logic [OFFSET_W-1:0] off);
        logic [NUM_W-1:0] idx;
        idx = n - 1'b1;
        sec = SECTOR_W'(BOOT_SECTORS + imap_cfg + smap_cfg + idx / RECS_PER_SECTOR);
        off = OFFSET_W'((idx % RECS_PER_SECTOR) * INODE_BYTES_DEF);
    endfunction

    function automatic res_t predict_inode_op(input logic [OP_W-1:0] o,
                                              input logic [DEV_W-1:0] dev,
                                              input logic [NUM_W-1:0] num,
                                              input logic [SLOT_W-1:0] s);
        res_t r;
        int   free_slot;
        int   i;
        bit   hit;
        r         = '0;
        free_slot = -1;
        hit       = 1'b0;
        if (o == OP_GET)
        begin
            if (num == '0)
            begin
                r.status = ST_INODE_ZERO;
            end
            else
            begin
                for (i = 0; i < NSLOTS && !hit; i++)
                begin
                    if (slot_count[i] != '0)
                    begin
                        if (slot_device[i] == dev && slot_inode[i] == num)
                        begin
                            hit = 1'b1;
                            if (slot_count[i] != COUNT_MAX)
                                slot_count[i]++;
                            r.status = ST_HIT;
                            r.slot   = SLOT_W'(i);
                            r.count  = slot_count[i];
                            place_record(num, r.sector, r.offset);
                        end
                    end
                    else if (free_slot < 0)
                    begin
                        free_slot = i;
                    end
                end
                if (!hit && free_slot < 0)
                begin
                    r.status = ST_FULL;
                end
                else if (!hit)
                begin
                    slot_device[free_slot] = dev;
                    slot_inode[free_slot]  = num;
                    slot_count[free_slot]  = COUNT_W'(1);
                    r.status = ST_CLAIMED;
                    r.slot   = SLOT_W'(free_slot);
                    r.count  = COUNT_W'(1);
                    place_record(num, r.sector, r.offset);
                end
            end
        end
        else if (o == OP_PUT || o == OP_LOCATE)
        begin
            r.slot = s;
            if (int'(s) >= NSLOTS || slot_count[s] == '0)
            begin
                r.status = ST_UNUSED;
            end
            else
            begin
                if (o == OP_PUT)
                    slot_count[s]--;
                r.status = ST_HIT;
                r.count  = slot_count[s];
                place_record(slot_inode[s], r.sector, r.offset);
            end
        end
        else
        begin
            r.status = ST_UNUSED;
        end
        return r;
    endfunction

    function automatic int pick_used_slot();
        int used[$];
        int i;
        for (i = 0; i < NSLOTS; i++)
            if (slot_count[i] != '0)
                used.push_back(i);
        if (used.size() == 0)
            return -1;
        return used[$urandom_range(0, used.size() - 1)];
    endfunction

    function automatic int first_free_slot();
        int i;
        for (i = 0; i < NSLOTS; i++)
            if (slot_count[i] == '0)
                return i;
        return -1;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (got_v !== exp_v)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, exp_v, got_v);
            errors++;
        end
    endtask

    task automatic send_req(input logic [OP_W-1:0] o, input logic [DEV_W-1:0] dev,
                            input logic [NUM_W-1:0] num, input logic [SLOT_W-1:0] s,
                            input bit known, input res_t known_res);
        res_t r;
        int   gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge clk);
        req_valid    <= 1'b1;
        op           <= o;
        device       <= dev;
        inode_number <= num;
        slot_in      <= s;
        do @(posedge clk); while (!req_ready);
        r = predict_inode_op(o, dev, num, s);
        results_due.push_back(known ? known_res : r);
        items_sent++;
    endtask

    // let every outstanding beat come back before touching the registers
    task automatic settle();
        @(negedge clk);
        req_valid <= 1'b0;
        burst_left = 0;
        while (results_due.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_IMAP)
            imap_cfg = val[IMAP_W-1:0];
        else if (idx == CFG_SMAP)
            smap_cfg = val;
    endtask

    task automatic dir_row(input logic [OP_W-1:0] o, input logic [DEV_W-1:0] dev,
                           input logic [NUM_W-1:0] num, input logic [SLOT_W-1:0] s);
        dir_row_t row;
        row.op    = o;
        row.dev   = dev;
        row.num   = num;
        row.slot  = s;
        row.known = 1'b0;
        row.res   = '0;
        dir_rows.push_back(row);
    endtask

    task automatic dir_known(input logic [OP_W-1:0] o, input logic [DEV_W-1:0] dev,
                             input logic [NUM_W-1:0] num, input logic [SLOT_W-1:0] s,
                             input status_t st, input logic [SLOT_W-1:0] so,
                             input logic [SECTOR_W-1:0] sec,
                             input logic [OFFSET_W-1:0] off,
                             input logic [COUNT_W-1:0] cnt);
        dir_row_t row;
        row.op         = o;
        row.dev        = dev;
        row.num        = num;
        row.slot       = s;
        row.known      = 1'b1;
        row.res.status = st;
        row.res.slot   = so;
        row.res.sector = sec;
        row.res.offset = off;
        row.res.count  = cnt;
        dir_rows.push_back(row);
    endtask

    task automatic new_pool();
        int k;
        for (k = 0; k < POOL_SIZE; k++)
        begin
            pool_dev[k] = DEV_W'($urandom);
            pool_num[k] = NUM_W'($urandom_range(1, 4095));
            // near misses: same device with another inode, same inode elsewhere
            if (k % 2 == 1)
                pool_dev[k] = pool_dev[k - 1];
        end
        pool_num[2] = pool_num[0];
    endtask

    task automatic run_workset();
        int n;
        int k;
        int s;
        int pick;
        n = $urandom_range(8, 20);
        repeat (n)
        begin
            pick = $urandom_range(0, 9);
            s    = pick_used_slot();
            if (pick < 5 || s < 0)
            begin
                k = $urandom_range(0, POOL_SIZE - 1);
                send_req(OP_GET, pool_dev[k], pool_num[k], SLOT_W'($urandom), 1'b0, '0);
            end
            else
            begin
                send_req(pick < 8 ? OP_PUT : OP_LOCATE, DEV_W'($urandom),
                         NUM_W'($urandom), SLOT_W'(s), 1'b0, '0);
            end
        end
    endtask

    task automatic run_noise();
        logic [OP_W-1:0]  o;
        logic [NUM_W-1:0] num;
        repeat ($urandom_range(3, 8))
        begin
            o   = OP_W'($urandom_range(0, 3));
            num = ($urandom_range(0, 3) == 0) ? '0 : NUM_W'($urandom_range(1, 4095));
            send_req(o, DEV_W'($urandom), num, SLOT_W'($urandom_range(0, 63)), 1'b0, '0);
        end
    endtask

    task automatic run_fill();
        int guard;
        guard = 0;
        while (first_free_slot() >= 0 && guard < NSLOTS + 8)
        begin
            send_req(OP_GET, DEV_W'($urandom), NUM_W'($urandom_range(1, 4095)),
                     SLOT_W'($urandom), 1'b0, '0);
            guard++;
        end
        repeat (2)
            send_req(OP_GET, DEV_W'($urandom), NUM_W'($urandom_range(1, 4095)),
                     SLOT_W'($urandom), 1'b0, '0);
    endtask

    task automatic run_drain();
        int s;
        for (s = 0; s < NSLOTS; s++)
            if (slot_count[s] != '0 && $urandom_range(0, 1) == 1)
                send_req(OP_PUT, DEV_W'($urandom), NUM_W'($urandom), SLOT_W'(s),
                         1'b0, '0);
    endtask

    task automatic run_saturate();
        int s;
        int i;
        if (first_free_slot() < 0)
        begin
            s = 0;
            for (i = 1; i < NSLOTS; i++)
                if (slot_count[i] < slot_count[s])
                    s = i;
            repeat (slot_count[s])
                send_req(OP_PUT, DEV_W'($urandom), NUM_W'($urandom), SLOT_W'(s),
                         1'b0, '0);
        end
        repeat (SAT_HITS)
            send_req(OP_GET, pool_dev[0], pool_num[0], SLOT_W'($urandom), 1'b0, '0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (results_due.size() == 0)
            begin
                $display("%0t: beat with nothing due, got status %0h slot %0h", $time,
                         status, slot_out);
                errors++;
            end
            else
            begin
                want_res = results_due.pop_front();
                check_field("status", 32'(want_res.status), 32'(status));
                check_field("slot_out", 32'(want_res.slot), 32'(slot_out));
                check_field("sector", want_res.sector, sector);
                check_field("byte_offset", 32'(want_res.offset), 32'(byte_offset));
                check_field("use_count", 32'(want_res.count), 32'(use_count));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || cfg_write)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_rsp)
            begin
                hold_rsp = 1'b0;
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else
            begin
                if (pat_left == 0)
                begin
                    pat_mode  = $urandom_range(0, 2);
                    stall_pat = 16'($urandom);
                    pat_left  = $urandom_range(16, 96);
                end
                pat_left--;
                pat_pos = (pat_pos + 1) % 16;
                case (pat_mode)
                    0:       rsp_ready <= 1'b1;
                    1:       rsp_ready <= stall_pat[pat_pos[3:0]];
                    default: rsp_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial
    begin
        int p;
        int pick;
        int phase_end;
        int i;
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = CFG_IMAP;
        cfg_data     = '0;
        req_valid    = 1'b0;
        op           = OP_GET;
        device       = '0;
        inode_number = '0;
        slot_in      = '0;
        for (i = 0; i < NSLOTS; i++)
        begin
            slot_count[i]  = '0;
            slot_device[i] = '0;
            slot_inode[i]  = '0;
        end
        imap_cfg = IMAP_RESET;
        smap_cfg = SMAP_RESET;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset maps: records start at sector 4
        dir_known(OP_GET, 16'h0000, 12'h000, 6'd0, ST_INODE_ZERO, 6'd0,
                  32'd0, 9'd0, 8'd0);
        dir_known(OP_GET, 16'hFFFF, 12'h000, 6'd63, ST_INODE_ZERO, 6'd0,
                  32'd0, 9'd0, 8'd0);
        dir_known(OP_PUT, 16'h0000, 12'h000, 6'd0, ST_UNUSED, 6'd0,
                  32'd0, 9'd0, 8'd0);
        dir_known(OP_LOCATE, 16'hFFFF, 12'hFFF, 6'd63, ST_UNUSED, 6'd63,
                  32'd0, 9'd0, 8'd0);
        dir_known(OP_UNKNOWN, 16'hFFFF, 12'hFFF, 6'd63, ST_UNUSED, 6'd0,
                  32'd0, 9'd0, 8'd0);
        dir_known(OP_UNKNOWN, 16'h0000, 12'h000, 6'd0, ST_UNUSED, 6'd0,
                  32'd0, 9'd0, 8'd0);
        dir_known(OP_GET, 16'hFFFF, 12'hFFF, 6'd0, ST_CLAIMED, 6'd0,
                  32'd259, 9'd448, 8'd1);
        dir_known(OP_GET, 16'h0000, 12'h001, 6'd63, ST_CLAIMED, 6'd1,
                  32'd4, 9'd0, 8'd1);
        dir_known(OP_GET, 16'hFFFF, 12'hFFF, 6'd0, ST_HIT, 6'd0,
                  32'd259, 9'd448, 8'd2);
        dir_row(OP_GET, 16'h0000, 12'hFFF, 6'd0);
        dir_row(OP_GET, 16'hFFFF, 12'h001, 6'd0);
        dir_row(OP_GET, 16'h5555, 12'hAAA, 6'd21);
        dir_row(OP_LOCATE, 16'h0000, 12'h000, 6'd0);
        dir_row(OP_PUT, 16'h0000, 12'h000, 6'd1);
        dir_known(OP_LOCATE, 16'h0000, 12'h000, 6'd1, ST_UNUSED, 6'd1,
                  32'd0, 9'd0, 8'd0);
        dir_known(OP_PUT, 16'h0000, 12'h000, 6'd1, ST_UNUSED, 6'd1,
                  32'd0, 9'd0, 8'd0);
        dir_row(OP_GET, 16'hAAAA, 12'h555, 6'd42);
        dir_row(OP_GET, 16'h0000, 12'h001, 6'd0);
        dir_row(OP_PUT, 16'h0000, 12'h000, 6'd0);
        dir_row(OP_PUT, 16'h0000, 12'h000, 6'd0);
        dir_known(OP_LOCATE, 16'h0000, 12'h000, 6'd0, ST_UNUSED, 6'd0,
                  32'd0, 9'd0, 8'd0);
        dir_row(OP_GET, 16'h5555, 12'hAAA, 6'd0);
        dir_row(OP_GET, 16'hFFFF, 12'hFFF, 6'd0);
        dir_row(OP_PUT, 16'h0000, 12'h000, 6'd2);
        dir_row(OP_LOCATE, 16'h0000, 12'h000, 6'd3);

        foreach (dir_rows[i])
            send_req(dir_rows[i].op, dir_rows[i].dev, dir_rows[i].num, dir_rows[i].slot,
                     dir_rows[i].known, dir_rows[i].res);

        for (p = 0; p < 4; p++)
        begin
            settle();
            case (p)
                0:
                begin
                    write_reg(CFG_IMAP, '0);
                    write_reg(CFG_SMAP, '0);
                end
                1:
                begin
                    write_reg(CFG_IMAP, 16'h00FF);
                    write_reg(CFG_SMAP, 16'hFFFF);
                end
                2:
                begin
                    write_reg(CFG_IMAP, CFG_DATA_W'($urandom));
                    write_reg(CFG_SMAP, CFG_DATA_W'($urandom));
                end
                default:
                begin
                    write_reg(CFG_NONE, CFG_DATA_W'($urandom));
                    write_reg(CFG_IMAP, CFG_DATA_W'($urandom));
                    write_reg(CFG_SMAP, CFG_DATA_W'($urandom_range(0, 255)));
                end
            endcase
            new_pool();
            phase_end = items_sent + PHASE_ITEMS;
            if (p == 0)
                run_fill();
            if (p == 1)
                hold_rsp = 1'b1;
            if (p == 2)
                run_saturate();
            while (items_sent < phase_end)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    run_workset();
                else if (pick == 6)
                    run_noise();
                else if (pick == 7)
                    run_fill();
                else
                    run_drain();
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
